FILE: hw/rtl/status_led_pattern_controller_assert.svh
// ----------------------------------------------------------------------------
// Status light controller assertion macros
// Concurrent assertion wrappers clocked on i_clk, with or without reset gating.
// ----------------------------------------------------------------------------
`ifndef STATUS_LED_PATTERN_CONTROLLER_ASSERT_SVH
`define STATUS_LED_PATTERN_CONTROLLER_ASSERT_SVH

`ifndef ASSERT_OFF
// assertion disabled while reset is low
`define SLPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// assertion checked on every edge, reset included
`define SLPC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SLPC_ASSERT(lbl, prop, msg)
`define SLPC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hw/rtl/slpc_pkg.sv
// ----------------------------------------------------------------------------
// slpc_pkg
// Shared types, register map and reset values of the status light controller.
// ----------------------------------------------------------------------------
`default_nettype none

package slpc_pkg;

    // display mode codes, as seen on the output
    typedef enum logic [3:0] {
        MODE_OFF       = 4'd0,
        MODE_CHARGING  = 4'd1,
        MODE_FULL      = 4'd2,
        MODE_HIGH_SOC  = 4'd3,
        MODE_LOW_SOC   = 4'd4,
        MODE_CHG_FAULT = 4'd5,
        MODE_DSG_FAULT = 4'd6,
        MODE_UNDERVOLT = 4'd7,
        MODE_ALARM1    = 4'd8,
        MODE_ALARM2    = 4'd9
    } t_mode;

    // breathing sequencer
    typedef enum logic [3:0] {
        PH_UP   = 4'b0001,
        PH_HIGH = 4'b0010,
        PH_DOWN = 4'b0100,
        PH_LOW  = 4'b1000
    } t_phase;

    // communication override codes
    localparam logic [1:0] COMM_NORMAL = 2'd0;
    localparam logic [1:0] COMM_OFF    = 2'd1;
    localparam logic [1:0] COMM_ALARM1 = 2'd2;
    localparam logic [1:0] COMM_ALARM2 = 2'd3;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_RAMP_STEP   = 3'd0;
    localparam logic [2:0] REG_RAMP_TOP    = 3'd1;
    localparam logic [2:0] REG_HOLD_TICKS  = 3'd2;
    localparam logic [2:0] REG_LOW_SOC_THR = 3'd3;
    localparam logic [2:0] REG_FAST_BLINK  = 3'd4;
    localparam logic [2:0] REG_ALARM1_BLK  = 3'd5;
    localparam logic [2:0] REG_SLOW_BLINK  = 3'd6;

    localparam int unsigned PADDR_W = 5;

    // register reset values
    localparam logic [8:0] RST_RAMP_STEP   = 9'd5;
    localparam logic [9:0] RST_RAMP_TOP    = 10'd500;
    localparam logic [7:0] RST_HOLD_TICKS  = 8'd25;
    localparam logic [6:0] RST_LOW_SOC_THR = 7'd20;
    localparam logic [7:0] RST_FAST_BLINK  = 8'd1;
    localparam logic [7:0] RST_ALARM1_BLK  = 8'd15;
    localparam logic [7:0] RST_SLOW_BLINK  = 8'd4;

    localparam logic [6:0] SOC_FULL        = 7'd100;
    localparam logic [9:0] LEVEL_MAX       = 10'd1023;

    typedef struct packed {
        logic [8:0] ramp_step;
        logic [9:0] ramp_top;
        logic [7:0] hold_ticks;
        logic [6:0] low_soc_thr;
        logic [7:0] fast_period;
        logic [7:0] alarm1_period;
        logic [7:0] slow_period;
    } t_cfg;

    // one input word, as held in the input register
    typedef struct packed {
        logic [7:0] count_10ms;
        logic [7:0] count_250ms;
        logic       charger_checking;
        logic       charger_present;
        logic [2:0] charge_faults;
        logic [1:0] full_flags;
        logic [6:0] soc_percent;
        logic       discharge_fault;
        logic       undervoltage;
        logic       discharging;
        logic [1:0] comm_mode;
    } t_in_word;

    // light state carried from word to word
    typedef struct packed {
        t_phase     phase;
        logic [9:0] level;
        logic [7:0] hold;
        logic [7:0] last_breath;
        logic [7:0] last_fast;
        logic [7:0] last_alarm1;
        logic [7:0] last_slow;
        logic       red;
    } t_light_state;

endpackage

`default_nettype wire

FILE: hw/rtl/slpc_mode_sel.sv
// ----------------------------------------------------------------------------
// slpc_mode_sel
// Fixed-priority display mode selection from the pack status flags.
// ----------------------------------------------------------------------------
`default_nettype none

module slpc_mode_sel
    import slpc_pkg::*;
(
    input  var t_in_word   i_word,
    input  var logic [6:0] i_low_soc_thr,
    output t_mode          o_mode
);

    t_mode w_dsg_mode;

    // discharge-side mode with the comm override applied
    always_comb begin
        w_dsg_mode = (i_word.soc_percent > i_low_soc_thr) ? MODE_HIGH_SOC : MODE_LOW_SOC;
        unique case (i_word.comm_mode)
            COMM_OFF:    w_dsg_mode = MODE_OFF;
            COMM_ALARM1: w_dsg_mode = MODE_ALARM1;
            COMM_ALARM2: w_dsg_mode = MODE_ALARM2;
            default:     ;
        endcase
    end

    always_comb begin
        priority if (i_word.charge_faults[0]) begin
            o_mode = MODE_CHG_FAULT;
        end else if (i_word.charger_present) begin
            priority if (i_word.charge_faults[1]) begin
                o_mode = MODE_CHG_FAULT;
            end else if (i_word.charge_faults[2]) begin
                o_mode = MODE_OFF;
            end else if (i_word.full_flags[0] && (i_word.soc_percent == SOC_FULL)) begin
                o_mode = i_word.full_flags[1] ? MODE_OFF : MODE_FULL;
            end else begin
                o_mode = MODE_CHARGING;
            end
        end else if (i_word.discharge_fault) begin
            o_mode = MODE_DSG_FAULT;
        end else if (i_word.undervoltage) begin
            o_mode = MODE_UNDERVOLT;
        end else if (!i_word.discharging) begin
            o_mode = MODE_OFF;
        end else begin
            o_mode = w_dsg_mode;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/slpc_light.sv
// ----------------------------------------------------------------------------
// slpc_light
// Next light state: breathing sequencer for blue, blink timers for red.
// ----------------------------------------------------------------------------
`default_nettype none

module slpc_light
    import slpc_pkg::*;
(
    input  var t_cfg         i_cfg,
    input  var t_mode        i_mode,
    input  var logic [7:0]   i_count_10ms,
    input  var logic [7:0]   i_count_250ms,
    input  var t_light_state i_state,
    output t_light_state     o_state
);

    logic [10:0] w_up_sum;
    logic [9:0]  w_up_level;
    logic [9:0]  w_down_level;
    logic [7:0]  w_hold_inc;
    logic        w_hold_done;
    logic [7:0]  w_fast_gap;
    logic [7:0]  w_slow_gap;
    logic [7:0]  w_alarm1_gap;
    t_light_state w_breath;

    assign w_up_sum     = {1'b0, i_state.level} + {2'b00, i_cfg.ramp_step};
    assign w_up_level   = w_up_sum[10] ? LEVEL_MAX : w_up_sum[9:0];
    assign w_down_level = (i_state.level > {1'b0, i_cfg.ramp_step})
                        ? (i_state.level - {1'b0, i_cfg.ramp_step}) : 10'd0;
    assign w_hold_inc   = i_state.hold + 8'd1;
    assign w_hold_done  = (w_hold_inc >= i_cfg.hold_ticks);

    assign w_fast_gap   = i_count_250ms - i_state.last_fast;
    assign w_slow_gap   = i_count_250ms - i_state.last_slow;
    assign w_alarm1_gap = i_count_10ms - i_state.last_alarm1;

    // one breathing step, taken on a new 10 ms tick
    always_comb begin
        w_breath = i_state;
        w_breath.last_breath = i_count_10ms;
        unique case (i_state.phase)
            PH_UP: begin
                if (i_state.level >= i_cfg.ramp_top) begin
                    w_breath.phase = PH_HIGH;
                    w_breath.hold  = 8'd0;
                end else begin
                    w_breath.level = w_up_level;
                end
            end
            PH_HIGH: begin
                w_breath.level = i_cfg.ramp_top;
                w_breath.hold  = w_hold_done ? 8'd0 : w_hold_inc;
                if (w_hold_done) w_breath.phase = PH_DOWN;
            end
            PH_DOWN: begin
                if (i_state.level == 10'd0) begin
                    w_breath.phase = PH_LOW;
                    w_breath.hold  = 8'd0;
                end else begin
                    w_breath.level = w_down_level;
                end
            end
            default: begin
                w_breath.level = 10'd0;
                w_breath.hold  = w_hold_done ? 8'd0 : w_hold_inc;
                if (w_hold_done) w_breath.phase = PH_UP;
            end
        endcase
    end

    always_comb begin
        o_state = i_state;
        unique case (i_mode)
            MODE_CHARGING: begin
                o_state.red = 1'b0;
                if (i_count_10ms != i_state.last_breath) begin
                    o_state = w_breath;
                    o_state.red = 1'b0;
                end
            end
            MODE_FULL, MODE_HIGH_SOC: begin
                o_state.red   = 1'b0;
                o_state.level = i_cfg.ramp_top;
                o_state.phase = PH_DOWN;
            end
            MODE_LOW_SOC: begin
                o_state.level = 10'd0;
                o_state.phase = PH_UP;
                o_state.red   = 1'b1;
            end
            MODE_CHG_FAULT, MODE_DSG_FAULT: begin
                o_state.level = 10'd0;
                o_state.phase = PH_UP;
                if (w_fast_gap >= i_cfg.fast_period) begin
                    o_state.last_fast = i_count_250ms;
                    o_state.red       = ~i_state.red;
                end
            end
            MODE_UNDERVOLT, MODE_ALARM2: begin
                o_state.level = 10'd0;
                o_state.phase = PH_UP;
                if (w_slow_gap >= i_cfg.slow_period) begin
                    o_state.last_slow = i_count_250ms;
                    o_state.red       = ~i_state.red;
                end
            end
            MODE_ALARM1: begin
                o_state.level = 10'd0;
                o_state.phase = PH_UP;
                if (w_alarm1_gap >= i_cfg.alarm1_period) begin
                    o_state.last_alarm1 = i_count_10ms;
                    o_state.red         = ~i_state.red;
                end
            end
            default: begin
                // off, and any code that means nothing
                o_state.level = 10'd0;
                o_state.phase = PH_UP;
                o_state.red   = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/status_led_pattern_controller.sv
// ----------------------------------------------------------------------------
// status_led_pattern_controller
// Battery-pack status light controller: mode select, breathing blue, blinking red.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one status word per
//   handshake: tick counts, pack flags, charge percent and comm override.
//   Output channel (o_out_valid / i_out_ready) returns one word per input
//   word: blue PWM level, red light state and the display mode.
//   The word sits in the input register, then the mode select and light
//   update run between that register and the output register.
//   Throughput is one word per cycle while the receiver does not stall.
//   When the receiver stalls, the output register holds its word and the
//   input register still takes one more word; beyond that o_in_ready drops.
//   Reset (i_rst_n low, synchronous) empties both registers, sets the mode
//   to off with both lights dark and loads the register defaults.
//   Registers sit on an APB-style port at byte offsets 4*i; the user must
//   write them only while no word is in flight, as the block has no guard.
// ----------------------------------------------------------------------------
`default_nettype none

module status_led_pattern_controller
    import slpc_pkg::*;
(
    input  var logic               i_clk,
    input  var logic               i_rst_n,

    input  var logic               i_in_valid,
    output logic                   o_in_ready,
    input  var logic [7:0]         i_count_10ms,
    input  var logic [7:0]         i_count_250ms,
    input  var logic               i_charger_checking,
    input  var logic               i_charger_present,
    input  var logic [2:0]         i_charge_faults,
    input  var logic [1:0]         i_full_flags,
    input  var logic [6:0]         i_soc_percent,
    input  var logic               i_discharge_fault,
    input  var logic               i_undervoltage,
    input  var logic               i_discharging,
    input  var logic [1:0]         i_comm_mode,

    output logic                   o_out_valid,
    input  var logic               i_out_ready,
    output logic [9:0]             o_blue_level,
    output logic                   o_red_on,
    output logic [3:0]             o_display_mode,

    input  var logic               psel,
    input  var logic               penable,
    input  var logic               pwrite,
    input  var logic [PADDR_W-1:0] paddr,
    input  var logic [31:0]        pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

`include "status_led_pattern_controller_assert.svh"

    t_cfg         r_cfg;
    t_in_word     r_in;
    logic         r_in_valid;
    logic         r_out_valid;
    logic [9:0]   r_out_level;
    logic         r_out_red;
    t_mode        r_out_mode;
    t_mode        r_mode;
    t_light_state r_light;

    t_mode        w_sel_mode;
    t_mode        n_mode;
    t_light_state n_light;
    logic         w_advance;
    logic         w_cfg_wr;
    logic [2:0]   w_reg_idx;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ramp_step     <= RST_RAMP_STEP;
            r_cfg.ramp_top      <= RST_RAMP_TOP;
            r_cfg.hold_ticks    <= RST_HOLD_TICKS;
            r_cfg.low_soc_thr   <= RST_LOW_SOC_THR;
            r_cfg.fast_period   <= RST_FAST_BLINK;
            r_cfg.alarm1_period <= RST_ALARM1_BLK;
            r_cfg.slow_period   <= RST_SLOW_BLINK;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_RAMP_STEP:   r_cfg.ramp_step     <= pwdata[8:0];
                REG_RAMP_TOP:    r_cfg.ramp_top      <= pwdata[9:0];
                REG_HOLD_TICKS:  r_cfg.hold_ticks    <= pwdata[7:0];
                REG_LOW_SOC_THR: r_cfg.low_soc_thr   <= pwdata[6:0];
                REG_FAST_BLINK:  r_cfg.fast_period   <= pwdata[7:0];
                REG_ALARM1_BLK:  r_cfg.alarm1_period <= pwdata[7:0];
                REG_SLOW_BLINK:  r_cfg.slow_period   <= pwdata[7:0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_RAMP_STEP:   prdata = {23'd0, r_cfg.ramp_step};
            REG_RAMP_TOP:    prdata = {22'd0, r_cfg.ramp_top};
            REG_HOLD_TICKS:  prdata = {24'd0, r_cfg.hold_ticks};
            REG_LOW_SOC_THR: prdata = {25'd0, r_cfg.low_soc_thr};
            REG_FAST_BLINK:  prdata = {24'd0, r_cfg.fast_period};
            REG_ALARM1_BLK:  prdata = {24'd0, r_cfg.alarm1_period};
            REG_SLOW_BLINK:  prdata = {24'd0, r_cfg.slow_period};
            default:         prdata = 32'd0;
        endcase
    end

    // ---------------- input register ----------------
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in.count_10ms       <= i_count_10ms;
            r_in.count_250ms      <= i_count_250ms;
            r_in.charger_checking <= i_charger_checking;
            r_in.charger_present  <= i_charger_present;
            r_in.charge_faults    <= i_charge_faults;
            r_in.full_flags       <= i_full_flags;
            r_in.soc_percent      <= i_soc_percent;
            r_in.discharge_fault  <= i_discharge_fault;
            r_in.undervoltage     <= i_undervoltage;
            r_in.discharging      <= i_discharging;
            r_in.comm_mode        <= i_comm_mode;
        end
    end

    // ---------------- mode and light update ----------------
    slpc_mode_sel u_mode_sel (
        .i_word        (r_in),
        .i_low_soc_thr (r_cfg.low_soc_thr),
        .o_mode        (w_sel_mode)
    );

    // hold the mode while the charger check runs
    assign n_mode = r_in.charger_checking ? r_mode : w_sel_mode;

    slpc_light u_light (
        .i_cfg         (r_cfg),
        .i_mode        (n_mode),
        .i_count_10ms  (r_in.count_10ms),
        .i_count_250ms (r_in.count_250ms),
        .i_state       (r_light),
        .o_state       (n_light)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode              <= MODE_OFF;
            r_light.phase       <= PH_DOWN;
            r_light.level       <= 10'd0;
            r_light.hold        <= 8'd0;
            r_light.last_breath <= 8'd0;
            r_light.last_fast   <= 8'd0;
            r_light.last_alarm1 <= 8'd0;
            r_light.last_slow   <= 8'd0;
            r_light.red         <= 1'b0;
        end else if (w_advance) begin
            r_mode  <= n_mode;
            r_light <= n_light;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_level <= n_light.level;
            r_out_red   <= n_light.red;
            r_out_mode  <= n_mode;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_blue_level   = r_out_level;
    assign o_red_on       = r_out_red;
    assign o_display_mode = r_out_mode;

    // ---------------- assertions ----------------
    `SLPC_ASSERT(a_blue_dark_unless_blue_mode,
        (r_out_valid && !(r_out_mode == MODE_CHARGING || r_out_mode == MODE_FULL
         || r_out_mode == MODE_HIGH_SOC)) |-> (r_out_level == 10'd0),
        "blue level lit outside a blue mode")
    `SLPC_ASSERT(a_red_dark_in_blue_mode,
        (r_out_valid && (r_out_mode == MODE_CHARGING || r_out_mode == MODE_FULL
         || r_out_mode == MODE_HIGH_SOC)) |-> !r_out_red,
        "red lit in a blue mode")
    `SLPC_ASSERT(a_check_holds_mode,
        (i_rst_n && w_advance && r_in.charger_checking) |=> (r_mode == $past(r_mode)),
        "mode changed during charger check")
    `SLPC_ASSERT(a_advance_fills_output,
        (i_rst_n && w_advance) |=> (r_out_valid && r_out_mode == r_mode),
        "result word lost or mode mismatch")
    `SLPC_ASSERT_ALWAYS(a_reset_empties,
        !i_rst_n |=> (!r_in_valid && !r_out_valid),
        "pipeline not empty after reset")

endmodule

`default_nettype wire

FILE: tb/tb_status_led_pattern_controller.sv
// ----------------------------------------------------------------------------
// tb_status_led_pattern_controller
// Self-checking bench for the battery-pack status light controller. A queue-fed
// driver offers status words, an in-bench model of mode select, breathing and
// blinking predicts each output word, and a monitor checks them in order under
// random gaps and stalls, across several register settings written over APB.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_status_led_pattern_controller;
    import slpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_STALL_AT  = 400;
    localparam int LONG_STALL_LEN = 120;
    localparam int SETTLE_CYCLES  = 4;
    localparam int MAX_PRINTS     = 30;
    localparam logic [2:0] REG_SPARE = 3'd7;

    typedef enum int {
        SC_NOISE, SC_CHARGING, SC_FULL, SC_HIGH, SC_LOW, SC_CHG_FAULT,
        SC_DSG_FAULT, SC_UNDERVOLT, SC_ALARM1, SC_ALARM2
    } t_scenario;

    typedef struct packed {
        logic [9:0] blue;
        logic       red;
        t_mode      mode;
    } t_light_out;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    t_in_word           tx_word = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [9:0]         o_blue_level;
    logic               o_red_on;
    logic [3:0]         o_display_mode;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    status_led_pattern_controller dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_count_10ms       (tx_word.count_10ms),
        .i_count_250ms      (tx_word.count_250ms),
        .i_charger_checking (tx_word.charger_checking),
        .i_charger_present  (tx_word.charger_present),
        .i_charge_faults    (tx_word.charge_faults),
        .i_full_flags       (tx_word.full_flags),
        .i_soc_percent      (tx_word.soc_percent),
        .i_discharge_fault  (tx_word.discharge_fault),
        .i_undervoltage     (tx_word.undervoltage),
        .i_discharging      (tx_word.discharging),
        .i_comm_mode        (tx_word.comm_mode),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_blue_level       (o_blue_level),
        .o_red_on           (o_red_on),
        .o_display_mode     (o_display_mode),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always #1 i_clk = ~i_clk;

    // light model state and its copy of the registers
    t_cfg       cfg;
    t_mode      cur_mode;
    t_phase     br_phase;
    logic [9:0] br_level;
    logic [7:0] br_hold;
    logic [7:0] last_breath;
    logic [7:0] last_fast;
    logic [7:0] last_alarm1;
    logic [7:0] last_slow;
    logic       red_q;

    t_in_word   pending_words[$];
    t_light_out expected_lights[$];

    logic       idle_on = 1'b1;
    logic       long_stall_done = 1'b0;
    int         tx_gap = 0;
    int         rx_gap = 0;
    int         words_sent = 0;
    int         words_checked = 0;
    int         mismatches = 0;
    int         quiet_cycles = 0;
    int         reg_settings = 0;
    logic [15:0] modes_seen = '0;
    logic [7:0] tick10 = '0;
    logic [7:0] tick250 = '0;

    function automatic t_mode pick_mode(input t_in_word w);
        t_mode m;
        if (w.charge_faults[0]) return MODE_CHG_FAULT;
        if (w.charger_present) begin
            if (w.charge_faults[1]) return MODE_CHG_FAULT;
            if (w.charge_faults[2]) return MODE_OFF;
            if (w.full_flags[0] && w.soc_percent == SOC_FULL) begin
                if (w.full_flags[1]) return MODE_OFF;
                else return MODE_FULL;
            end
            return MODE_CHARGING;
        end
        if (w.discharge_fault) return MODE_DSG_FAULT;
        if (w.undervoltage) return MODE_UNDERVOLT;
        if (!w.discharging) return MODE_OFF;
        if (w.soc_percent > cfg.low_soc_thr) m = MODE_HIGH_SOC;
        else m = MODE_LOW_SOC;
        case (w.comm_mode)
            COMM_OFF:    m = MODE_OFF;
            COMM_ALARM1: m = MODE_ALARM1;
            COMM_ALARM2: m = MODE_ALARM2;
            default:     ;
        endcase
        return m;
    endfunction

    task automatic breath_step();
        logic [10:0] sum;
        case (br_phase)
            PH_UP: begin
                if (br_level >= cfg.ramp_top) begin
                    br_phase = PH_HIGH;
                    br_hold  = '0;
                end else begin
                    sum = br_level + cfg.ramp_step;
                    br_level = (sum > LEVEL_MAX) ? LEVEL_MAX : sum[9:0];
                end
            end
            PH_HIGH: begin
                br_level = cfg.ramp_top;
                br_hold  = br_hold + 8'd1;
                if (br_hold >= cfg.hold_ticks) begin
                    br_phase = PH_DOWN;
                    br_hold  = '0;
                end
            end
            PH_DOWN: begin
                if (br_level == '0) begin
                    br_phase = PH_LOW;
                    br_hold  = '0;
                end else begin
                    br_level = (br_level > cfg.ramp_step) ? br_level - cfg.ramp_step : '0;
                end
            end
            default: begin
                br_level = '0;
                br_hold  = br_hold + 8'd1;
                if (br_hold >= cfg.hold_ticks) begin
                    br_phase = PH_UP;
                    br_hold  = '0;
                end
            end
        endcase
    endtask

    task automatic red_toggle(input logic [7:0] now, inout logic [7:0] last,
                              input logic [7:0] period);
        logic [7:0] diff;
        diff = now - last;
        if (diff >= period) begin
            last  = now;
            red_q = ~red_q;
        end
    endtask

    task automatic blue_dark();
        br_level = '0;
        br_phase = PH_UP;
    endtask

    task automatic predict_lights(input t_in_word w, output t_light_out r);
        if (!w.charger_checking) cur_mode = pick_mode(w);
        case (cur_mode)
            MODE_CHARGING: begin
                red_q = 1'b0;
                if (w.count_10ms != last_breath) begin
                    last_breath = w.count_10ms;
                    breath_step();
                end
            end
            MODE_FULL, MODE_HIGH_SOC: begin
                red_q    = 1'b0;
                br_level = cfg.ramp_top;
                br_phase = PH_DOWN;
            end
            MODE_LOW_SOC: begin
                blue_dark();
                red_q = 1'b1;
            end
            MODE_CHG_FAULT, MODE_DSG_FAULT: begin
                blue_dark();
                red_toggle(w.count_250ms, last_fast, cfg.fast_period);
            end
            MODE_UNDERVOLT, MODE_ALARM2: begin
                blue_dark();
                red_toggle(w.count_250ms, last_slow, cfg.slow_period);
            end
            MODE_ALARM1: begin
                blue_dark();
                red_toggle(w.count_10ms, last_alarm1, cfg.alarm1_period);
            end
            default: begin
                cur_mode = MODE_OFF;
                blue_dark();
                red_q = 1'b0;
            end
        endcase
        r.blue = br_level;
        r.red  = red_q;
        r.mode = cur_mode;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at output word %0d: %s got %0d, expected %0d",
                     words_checked, what, got, want);
    endtask

    // driver: hold the word until taken, then offer the next or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                t_light_out r;
                predict_lights(tx_word, r);
                expected_lights.push_back(r);
                words_sent++;
                if (idle_on && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 13);
            end
            if (!i_in_valid || o_in_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    tx_word    <= pending_words.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each taken word against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                t_light_out want;
                if (expected_lights.size() == 0) begin
                    report_mismatch("output word with nothing pending, mode",
                                    o_display_mode, -1);
                end else begin
                    want = expected_lights.pop_front();
                    if (o_blue_level !== want.blue)
                        report_mismatch("blue_level", o_blue_level, want.blue);
                    if (o_red_on !== want.red)
                        report_mismatch("red_on", o_red_on, want.red);
                    if (o_display_mode !== want.mode)
                        report_mismatch("display_mode", o_display_mode, want.mode);
                end
                modes_seen[o_display_mode] = 1'b1;
                words_checked++;
            end
            // hold off once for a long stretch so the input side backs up
            if (!long_stall_done && words_checked >= LONG_STALL_AT) begin
                long_stall_done = 1'b1;
                rx_gap = LONG_STALL_LEN;
            end else if (rx_gap == 0 && idle_on && $urandom_range(0, 7) == 0) begin
                rx_gap = $urandom_range(1, 13);
            end
            if (rx_gap > 0) begin
                rx_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles, %0d sent, %0d checked",
                         WATCHDOG_LIMIT, words_sent, words_checked);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic int reg_bits(input logic [2:0] idx);
        case (idx)
            REG_RAMP_STEP:   return 9;
            REG_RAMP_TOP:    return 10;
            REG_LOW_SOC_THR: return 7;
            default:         return 8;
        endcase
    endfunction

    task automatic set_reg(input logic [2:0] idx, input int unsigned value);
        logic [31:0] mask;
        logic [31:0] data;
        mask = (32'd1 << reg_bits(idx)) - 32'd1;
        data = ($urandom & ~mask) | (value & mask);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RAMP_STEP:   cfg.ramp_step     = data[8:0];
            REG_RAMP_TOP:    cfg.ramp_top      = data[9:0];
            REG_HOLD_TICKS:  cfg.hold_ticks    = data[7:0];
            REG_LOW_SOC_THR: cfg.low_soc_thr   = data[6:0];
            REG_FAST_BLINK:  cfg.fast_period   = data[7:0];
            REG_ALARM1_BLK:  cfg.alarm1_period = data[7:0];
            REG_SLOW_BLINK:  cfg.slow_period   = data[7:0];
            default:         ;
        endcase
    endtask

    task automatic set_all_regs(input int unsigned step, input int unsigned top,
                                input int unsigned hold, input int unsigned thr,
                                input int unsigned fast, input int unsigned alarm1,
                                input int unsigned slow);
        set_reg(REG_RAMP_STEP, step);
        set_reg(REG_RAMP_TOP, top);
        set_reg(REG_HOLD_TICKS, hold);
        set_reg(REG_LOW_SOC_THR, thr);
        set_reg(REG_FAST_BLINK, fast);
        set_reg(REG_ALARM1_BLK, alarm1);
        set_reg(REG_SLOW_BLINK, slow);
        reg_settings++;
    endtask

    function automatic int unsigned short_or_full(input int unsigned hi);
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, hi);
        return $urandom_range(0, 20);
    endfunction

    task automatic advance_ticks();
        if ($urandom_range(0, 49) == 0) tick10 = 8'($urandom);
        else tick10 = tick10 + 8'($urandom_range(0, 2));
        if ($urandom_range(0, 79) == 0) tick250 = 8'($urandom);
        else if ($urandom_range(0, 5) == 0) tick250 = tick250 + 8'd1;
    endtask

    function automatic t_in_word status_word(input t_scenario kind);
        t_in_word w;
        w = '0;
        w.count_10ms       = tick10;
        w.count_250ms      = tick250;
        w.charger_checking = ($urandom_range(0, 11) == 0);
        w.soc_percent      = 7'($urandom_range(0, 100));
        w.comm_mode        = COMM_NORMAL;
        case (kind)
            SC_CHARGING: begin
                w.charger_present = 1'b1;
                w.full_flags      = 2'($urandom);
                if ($urandom_range(0, 9) == 0) w.charge_faults = 3'b100;
            end
            SC_FULL: begin
                w.charger_present = 1'b1;
                w.full_flags      = ($urandom_range(0, 3) == 0) ? 2'b11 : 2'b01;
                w.soc_percent     = ($urandom_range(0, 5) == 0) ? 7'd99 : SOC_FULL;
            end
            SC_HIGH, SC_LOW: begin
                w.discharging = 1'b1;
                if (kind == SC_LOW)
                    w.soc_percent = 7'($urandom_range(0, int'(cfg.low_soc_thr)));
                else if (cfg.low_soc_thr >= 7'd100)
                    w.soc_percent = 7'($urandom);
                else
                    w.soc_percent = 7'($urandom_range(int'(cfg.low_soc_thr) + 1, 100));
                if ($urandom_range(0, 7) == 0) w.comm_mode = COMM_OFF;
            end
            SC_CHG_FAULT: begin
                w.charger_present = 1'($urandom);
                w.charge_faults   = 3'($urandom_range(1, 7));
                if (!w.charger_present) w.charge_faults[0] = 1'b1;
                w.full_flags      = 2'($urandom);
            end
            SC_DSG_FAULT: begin
                w.discharge_fault = 1'b1;
                w.undervoltage    = 1'($urandom);
                w.discharging     = 1'($urandom);
                w.comm_mode       = 2'($urandom);
            end
            SC_UNDERVOLT: begin
                w.undervoltage = 1'b1;
                w.discharging  = 1'($urandom);
                w.comm_mode    = 2'($urandom);
            end
            SC_ALARM1: begin
                w.discharging = 1'b1;
                w.comm_mode   = COMM_ALARM1;
            end
            SC_ALARM2: begin
                w.discharging = 1'b1;
                w.comm_mode   = COMM_ALARM2;
            end
            default: begin
                w = t_in_word'({$urandom, $urandom});
                w.count_10ms  = tick10;
                w.count_250ms = tick250;
            end
        endcase
        return w;
    endfunction

    // runs of one scenario with random content, mixed with noise
    task automatic fill_random(input int n);
        int count;
        int run_len;
        t_scenario kind;
        count = 0;
        while (count < n) begin
            if ($urandom_range(0, 7) == 0) kind = SC_NOISE;
            else kind = t_scenario'($urandom_range(1, 9));
            run_len = $urandom_range(8, 80);
            for (int k = 0; k < run_len && count < n; k++) begin
                advance_ticks();
                pending_words.push_back(status_word(kind));
                count++;
            end
        end
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || i_in_valid || expected_lights.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_in_word w;

        cfg.ramp_step     = RST_RAMP_STEP;
        cfg.ramp_top      = RST_RAMP_TOP;
        cfg.hold_ticks    = RST_HOLD_TICKS;
        cfg.low_soc_thr   = RST_LOW_SOC_THR;
        cfg.fast_period   = RST_FAST_BLINK;
        cfg.alarm1_period = RST_ALARM1_BLK;
        cfg.slow_period   = RST_SLOW_BLINK;
        cur_mode    = MODE_OFF;
        br_phase    = PH_DOWN;
        br_level    = '0;
        br_hold     = '0;
        last_breath = '0;
        last_fast   = '0;
        last_alarm1 = '0;
        last_slow   = '0;
        red_q       = 1'b0;
        reg_settings = 1;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words on the reset register values
        w = '0;
        pending_words.push_back(w);
        w.discharging = 1'b1;
        w.soc_percent = SOC_FULL;
        pending_words.push_back(w);
        w.soc_percent = RST_LOW_SOC_THR;
        pending_words.push_back(w);
        w.soc_percent = RST_LOW_SOC_THR + 7'd1;
        pending_words.push_back(w);
        w.comm_mode = COMM_OFF;
        pending_words.push_back(w);
        w.comm_mode = COMM_ALARM1;
        pending_words.push_back(w);
        w.comm_mode = COMM_ALARM2;
        w.count_250ms = 8'd4;
        pending_words.push_back(w);
        w = '0;
        w.undervoltage = 1'b1;
        w.discharging  = 1'b1;
        w.count_250ms  = 8'd255;
        pending_words.push_back(w);
        w.discharge_fault = 1'b1;
        pending_words.push_back(w);
        w = '0;
        w.charger_present = 1'b1;
        w.count_10ms = 8'd1;
        pending_words.push_back(w);
        pending_words.push_back(w);
        w.count_10ms = 8'd255;
        pending_words.push_back(w);
        w.full_flags  = 2'b01;
        w.soc_percent = SOC_FULL;
        pending_words.push_back(w);
        w.full_flags = 2'b11;
        pending_words.push_back(w);
        w.full_flags  = 2'b01;
        w.soc_percent = 7'd99;
        pending_words.push_back(w);
        w.charge_faults = 3'b100;
        pending_words.push_back(w);
        w.charge_faults = 3'b010;
        pending_words.push_back(w);
        w.charger_present = 1'b0;
        w.charge_faults   = 3'b001;
        pending_words.push_back(w);
        w = '0;
        w.charger_checking = 1'b1;
        w.discharging      = 1'b1;
        w.soc_percent      = 7'd50;
        pending_words.push_back(w);
        w = '1;
        w.charger_checking = 1'b0;
        pending_words.push_back(w);
        w = '1;
        pending_words.push_back(w);
        w = '0;
        w.discharging = 1'b1;
        w.soc_percent = 7'd127;
        pending_words.push_back(w);
        w.charger_checking = 1'b1;
        w.discharging      = 1'b0;
        pending_words.push_back(w);
        fill_random(150);
        drain();

        // steep ramp to the highest top, hold and blink periods of one
        set_all_regs(500, 1023, 1, 100, 1, 1, 1);
        fill_random(200);
        drain();

        // all zero: fixed level, one-tick hold, toggle on every word
        set_all_regs(0, 0, 0, 0, 0, 0, 0);
        fill_random(200);
        drain();

        // every register at the top of its width
        set_all_regs(511, 1023, 255, 127, 255, 255, 255);
        fill_random(200);
        drain();

        set_reg(REG_SPARE, $urandom);
        set_all_regs($urandom_range(1, 64), $urandom_range(1, 200), short_or_full(255),
                     $urandom_range(0, 100), short_or_full(255), short_or_full(255),
                     short_or_full(255));
        fill_random(200);
        drain();

        // closing stretch at full rate
        idle_on = 1'b0;
        set_all_regs($urandom_range(0, 511), $urandom_range(0, 1023), short_or_full(255),
                     $urandom_range(0, 127), short_or_full(255), short_or_full(255),
                     short_or_full(255));
        fill_random(275);
        drain();
        repeat (10) @(posedge i_clk);

        while (expected_lights.size() != 0) begin
            void'(expected_lights.pop_front());
            report_mismatch("missing output word, count", 0, 1);
        end

        $display("covered %0d status words under %0d register settings, long output stall %0s",
                 words_sent, reg_settings, long_stall_done ? "included" : "missed");
        $display("display modes observed: %0d of 10, mismatches: %0d",
                 $countones(modes_seen), mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
